/* sv/pbr_pkg.sv */
package pbr_pkg;

  localparam int DEFAULT_MAX_DEGREE = 6;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W = 3;
  localparam int DEG_REG_W = 3;
  localparam int ITER_W = 6;
  localparam int HALF_W = DATA_W / 2;
  localparam int ACC_W = 2 * DATA_W;
  localparam int MUL_STEPS = 4;

  localparam logic [IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF0 = 3'd1;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_LOAD,
    ST_MUL,
    ST_SAT,
    ST_ADD,
    ST_DECIDE,
    ST_FINAL
  } state_t;

  // floor((a+b)/2) without overflow
  function automatic logic [DATA_W-1:0] midpoint(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] x;
    x = a ^ b;
    return (a & b) + {x[DATA_W-1], x[DATA_W-1:1]};
  endfunction

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
      return a[DATA_W-1] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

endpackage

/* sv/polynomial_bisection_root_top.sv */
// each horner step loads operands, forms four 32x32 partial products on one shared multiplier,
// then saturates the product and adds the coefficient; one item is in flight at a time
// a new word is taken only when idle; busy stays high from start until done
// done marks root for one cycle; the receiver cannot stall
// reset: synchronous, degree returns to 1 and all coefficients to zero
module polynomial_bisection_root_top #(
  parameter int MAX_DEGREE = pbr_pkg::DEFAULT_MAX_DEGREE
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pbr_pkg::DATA_W-1:0]  lower_end,
  input  logic signed [pbr_pkg::DATA_W-1:0]  upper_end,
  input  logic                               sign_at_lower,
  input  logic        [pbr_pkg::ITER_W-1:0]  iterations,
  output logic                               done,
  output logic signed [pbr_pkg::DATA_W-1:0]  root,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [pbr_pkg::ADDR_W-1:0]  paddr,
  input  logic        [pbr_pkg::DATA_W-1:0]  pwdata,
  output logic        [pbr_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);
  import pbr_pkg::*;

  localparam int NCOEF = MAX_DEGREE + 1;
  localparam int DEG_W = $clog2(NCOEF);

  state_t state, state_next;

  logic [DEG_REG_W-1:0] degree;
  logic [DATA_W-1:0]    coef [NCOEF];

  logic [DATA_W-1:0] a, b, s, r, q, mr, mx;
  logic              lneg, pneg;
  logic [ITER_W-1:0] n, k;
  logic [DEG_W-1:0]  hidx;
  logic [2:0]        cnt;
  logic [1:0]        prod_idx;
  logic [DATA_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  logic [DEG_W-1:0]  deg_eff, rd_sel;
  logic [DATA_W-1:0] coef_rd;
  logic [HALF_W-1:0] op_a, op_b;
  logic [ACC_W-1:0]  pp_shifted;
  logic [IDX_W-1:0]  reg_idx;
  logic              cfg_wr;
  logic              over, frac, keep;
  logic [DATA_W-1:0] m_mid, q_calc;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEG_REG_W'(1);
      for (int j = 0; j < NCOEF; j++) begin
        coef[j] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == REG_DEGREE) begin
        degree <= pwdata[DEG_REG_W-1:0];
      end
      for (int j = 0; j < NCOEF; j++) begin
        if (reg_idx == REG_COEF0 + IDX_W'(j)) begin
          coef[j] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DEGREE) begin
      prdata = {{(DATA_W-DEG_REG_W){1'b0}}, degree};
    end
    for (int j = 0; j < NCOEF; j++) begin
      if (reg_idx == REG_COEF0 + IDX_W'(j)) begin
        prdata = coef[j];
      end
    end
  end

  // coefficient read port
  assign deg_eff = (degree > DEG_REG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree);
  assign rd_sel  = (state == ST_ADD) ? (hidx - 1'b1) : deg_eff;
  assign coef_rd = coef[rd_sel];

  // shared multiplier operands
  assign op_a = cnt[1] ? mr[DATA_W-1:HALF_W] : mr[HALF_W-1:0];
  assign op_b = cnt[0] ? mx[DATA_W-1:HALF_W] : mx[HALF_W-1:0];

  always_comb begin
    case (prod_idx) inside
      2'd0:       pp_shifted = {{DATA_W{1'b0}}, prod};
      2'd1, 2'd2: pp_shifted = {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};
      default:    pp_shifted = {prod, {DATA_W{1'b0}}};
    endcase
  end

  // floor and saturate the product
  assign over  = |acc[ACC_W-1:ACC_W-HALF_W];
  assign m_mid = acc[ACC_W-HALF_W-1:HALF_W];
  assign frac  = |acc[HALF_W-1:0];

  always_comb begin
    if (over || m_mid[DATA_W-1]) begin
      q_calc = pneg ? Q_MIN : Q_MAX;
    end else if (pneg) begin
      q_calc = ~m_mid + {{(DATA_W-1){1'b0}}, ~frac};
    end else begin
      q_calc = m_mid;
    end
  end

  assign keep = (r != '0) && (r[DATA_W-1] == lneg);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_MID;
      ST_MID:    state_next = (deg_eff == '0) ? ST_DECIDE : ST_LOAD;
      ST_LOAD:   state_next = ST_MUL;
      ST_MUL:    if (cnt == 3'(MUL_STEPS)) state_next = ST_SAT;
      ST_SAT:    state_next = ST_ADD;
      ST_ADD:    state_next = (hidx == DEG_W'(1)) ? ST_DECIDE : ST_LOAD;
      ST_DECIDE: state_next = (k == n) ? ST_FINAL : ST_MID;
      ST_FINAL:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FINAL);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          a    <= $unsigned(lower_end);
          b    <= $unsigned(upper_end);
          lneg <= sign_at_lower;
          n    <= iterations;
          k    <= '0;
        end
      end
      ST_MID: begin
        s    <= midpoint(a, b);
        r    <= coef_rd;
        hidx <= deg_eff;
      end
      ST_LOAD: begin
        mr   <= magnitude(r);
        mx   <= magnitude(s);
        pneg <= r[DATA_W-1] ^ s[DATA_W-1];
        acc  <= '0;
        cnt  <= '0;
      end
      ST_MUL: begin
        if (cnt < 3'(MUL_STEPS)) begin
          prod     <= DATA_W'(op_a) * DATA_W'(op_b);
          prod_idx <= cnt[1:0];
        end
        if (cnt != '0) begin
          acc <= acc + pp_shifted;
        end
        cnt <= cnt + 1'b1;
      end
      ST_SAT: begin
        q <= q_calc;
      end
      ST_ADD: begin
        r    <= sat_add(q, coef_rd);
        hidx <= hidx - 1'b1;
      end
      ST_DECIDE: begin
        if (keep) begin
          a <= s;
        end else begin
          b <= s;
        end
        k <= k + 1'b1;
      end
      ST_FINAL: begin
        root <= $signed(midpoint(a, b));
      end
      default: ;
    endcase
  end

  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FINAL)
    else $error("done without final step");

  a_start_enters_mid: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == ST_MID)
    else $error("accepted word did not start bisection");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> cnt <= 3'(MUL_STEPS))
    else $error("partial product count out of range");

  a_add_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |-> hidx != '0)
    else $error("horner index underflow");

endmodule

/* tb/sv/polynomial_bisection_root_top_test.sv */
module polynomial_bisection_root_top_test;
  import pbr_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = 16000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam logic [DATA_W-1:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [DATA_W-1:0] Q_TWO = 64'h0000_0002_0000_0000;
  localparam logic [DATA_W-1:0] Q_NEG_TWO = 64'hFFFF_FFFE_0000_0000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [DATA_W-1:0] lower_end;
  logic signed [DATA_W-1:0] upper_end;
  logic sign_at_lower;
  logic [ITER_W-1:0] iterations;
  logic done;
  logic signed [DATA_W-1:0] root;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [DEG_REG_W-1:0] cfg_degree;
  logic [DATA_W-1:0] cfg_coef [0:DEFAULT_MAX_DEGREE];
  logic [DATA_W-1:0] root_queue [$];
  int error_count = 0;
  int cycle_count = 0;

  polynomial_bisection_root_top i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .lower_end(lower_end),
    .upper_end(upper_end),
    .sign_at_lower(sign_at_lower),
    .iterations(iterations),
    .done(done),
    .root(root),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // floor((a+b)/2) from the 65-bit sum
  function automatic logic [DATA_W-1:0] q_half_sum(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return s[DATA_W:1];
  endfunction

  function automatic logic [DATA_W-1:0] q_sum(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // full signed product, floor shift by 32, saturate
  function automatic logic [DATA_W-1:0] q_product(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] pa;
    logic signed [2*DATA_W-1:0] pb;
    logic signed [2*DATA_W-1:0] pq;
    pa = {{DATA_W{a[DATA_W-1]}}, a};
    pb = {{DATA_W{b[DATA_W-1]}}, b};
    pq = (pa * pb) >>> HALF_W;
    if (pq[2*DATA_W-1:DATA_W-1] == '0 || pq[2*DATA_W-1:DATA_W-1] == '1) begin
      return pq[DATA_W-1:0];
    end
    return pq[2*DATA_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic [DATA_W-1:0] poly_value(input logic [DATA_W-1:0] x);
    int d;
    logic [DATA_W-1:0] r;
    d = (int'(cfg_degree) > DEFAULT_MAX_DEGREE) ? DEFAULT_MAX_DEGREE : int'(cfg_degree);
    r = cfg_coef[d];
    for (int i = d; i > 0; i--) begin
      r = q_sum(q_product(r, x), cfg_coef[i-1]);
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] predict_root(input logic [DATA_W-1:0] lo,
                                                     input logic [DATA_W-1:0] hi,
                                                     input logic sgn,
                                                     input logic [ITER_W-1:0] n);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    a = lo;
    b = hi;
    for (int k = 0; k <= int'(n); k++) begin
      m = q_half_sum(a, b);
      v = poly_value(m);
      // zero value moves the upper end
      if (v != '0 && v[DATA_W-1] == sgn) begin
        a = m;
      end else begin
        b = m;
      end
    end
    return q_half_sum(a, b);
  endfunction

  function automatic logic [DATA_W-1:0] rand_q();
    logic [DATA_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: return r;
      5, 6, 7: return {{28{r[35]}}, r[35:0]};
      default: return {{24{r[39]}}, r[39:0]};
    endcase
  endfunction

  // mostly short runs, a few long ones
  function automatic logic [ITER_W-1:0] rand_iters();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) begin
      return ITER_W'($urandom_range(0, 7));
    end
    if (p < 95) begin
      return ITER_W'($urandom_range(8, 31));
    end
    return ITER_W'($urandom_range(32, 63));
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_DEGREE) begin
      cfg_degree = value[DEG_REG_W-1:0];
    end else begin
      cfg_coef[idx - REG_COEF0] = value;
    end
  endtask

  task automatic send_word(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic sgn, input logic [ITER_W-1:0] n);
    start <= 1'b1;
    lower_end <= lo;
    upper_end <= hi;
    sign_at_lower <= sgn;
    iterations <= n;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    root_queue.push_back(predict_root(lo, hi, sgn, n));
  endtask

  task automatic idle_gap(input int cycles);
    if (start) begin
      start <= 1'b0;
    end
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    if (start) begin
      start <= 1'b0;
    end
    while (root_queue.size() != 0 || busy) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (root_queue.size() == 0) begin
        $display("%0t: root word with none expected, expected none, actual %h", $time, root);
        error_count++;
      end else begin
        if (root !== root_queue[0]) begin
          $display("%0t: root mismatch, expected %h, actual %h", $time, root_queue[0], root);
          error_count++;
        end
        void'(root_queue.pop_front());
      end
    end
  end

  // reset state: degree 1 with all-zero coefficients, p is zero everywhere
  task automatic test_zero_polynomial();
    send_word(Q_MIN, Q_MAX, 1'b0, 6'd63);
    send_word(Q_MAX, Q_MIN, 1'b1, 6'd0);
    send_word('0, '0, 1'b1, 6'd17);
    wait_idle();
  endtask

  task automatic test_quadratic();
    write_reg(REG_COEF0, Q_NEG_TWO);
    write_reg(REG_COEF0 + 3'd2, Q_ONE);
    write_reg(REG_DEGREE, 64'd2);
    send_word('0, Q_TWO, 1'b1, 6'd63);
    send_word(Q_NEG_TWO, '0, 1'b0, 6'd63);
    send_word(Q_TWO, '0, 1'b0, 6'd40);
    send_word(Q_ONE, Q_ONE, 1'b1, 6'd3);
    wait_idle();
    // root exactly on the first midpoint
    write_reg(REG_COEF0, -Q_ONE);
    send_word('0, Q_TWO, 1'b1, 6'd10);
    wait_idle();
  endtask

  task automatic test_degree_zero();
    write_reg(REG_DEGREE, 64'd0);
    write_reg(REG_COEF0, 3 * Q_ONE);
    send_word(-(4 * Q_ONE), 4 * Q_ONE, 1'b0, 6'd20);
    send_word(Q_MIN, Q_MAX, 1'b1, 6'd5);
    wait_idle();
    write_reg(REG_COEF0, Q_MIN);
    send_word(Q_MIN, Q_MAX, 1'b1, 6'd63);
    wait_idle();
  endtask

  // extreme coefficients, degree above the maximum and then at it
  task automatic test_saturation();
    for (int k = 0; k <= DEFAULT_MAX_DEGREE; k++) begin
      write_reg(REG_COEF0 + IDX_W'(k), (k % 2 == 0) ? Q_MAX : Q_MIN);
    end
    write_reg(REG_DEGREE, 64'd7);
    send_word(Q_MIN, Q_MAX, 1'b1, 6'd63);
    send_word(Q_MAX, Q_MIN, 1'b0, 6'd63);
    wait_idle();
    write_reg(REG_DEGREE, 64'd6);
    send_word(Q_MIN, Q_MAX, 1'b0, 6'd9);
    wait_idle();
  endtask

  // negative products with fraction bits below the lsb
  task automatic test_floor_rounding();
    write_reg(REG_DEGREE, 64'd1);
    write_reg(REG_COEF0, 64'd1);
    write_reg(REG_COEF0 + 3'd1, '1);
    send_word(64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_0000_0100, 1'b0, 6'd12);
    send_word(-(8 * Q_ONE), 8 * Q_ONE, 1'b1, 6'd30);
    wait_idle();
    write_reg(REG_COEF0 + 3'd1, Q_ONE - 64'd1);
    send_word(64'hFFFF_FFFF_0000_0001, 64'h0000_0003_8000_0001, 1'b1, 6'd45);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] v;
    logic sgn;
    int gap_pct;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: write_reg(REG_DEGREE, 64'd0);
        1: write_reg(REG_DEGREE, 64'd6);
        2: write_reg(REG_DEGREE, 64'd7);
        default: write_reg(REG_DEGREE, 64'($urandom_range(0, 7)));
      endcase
      for (int k = 0; k <= DEFAULT_MAX_DEGREE; k++) begin
        write_reg(REG_COEF0 + IDX_W'(k), rand_q());
      end
      gap_pct = (p == 3 || p == PHASES - 1) ? 0 : 35;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        lo = rand_q();
        hi = rand_q();
        if ($urandom_range(0, 9) < 7) begin
          v = poly_value(lo);
          sgn = v[DATA_W-1];
        end else begin
          sgn = 1'($urandom_range(0, 1));
        end
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
          idle_gap($urandom_range(1, 12));
        end
        send_word(lo, hi, sgn, rand_iters());
      end
    end
  endtask

  initial begin
    int waited;
    rst <= 1'b1;
    start <= 1'b0;
    lower_end <= '0;
    upper_end <= '0;
    sign_at_lower <= 1'b0;
    iterations <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_degree = 3'd1;
    for (int k = 0; k <= DEFAULT_MAX_DEGREE; k++) begin
      cfg_coef[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_polynomial();
    test_quadratic();
    test_degree_zero();
    test_saturation();
    test_floor_rounding();
    test_random_phases();

    if (start) begin
      start <= 1'b0;
    end
    waited = 0;
    while (root_queue.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    if (root_queue.size() != 0) begin
      $display("%0t: %0d roots missing, expected %h, actual none", $time,
               root_queue.size(), root_queue[0]);
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/pbr_pkg.sv
sv/polynomial_bisection_root_top.sv
tb/sv/polynomial_bisection_root_top_test.sv
